// ----- rtl/core/b32enc_pkg.sv -----
package b32enc_pkg;

    // Symbol and alphabet geometry
    localparam int SYM_BITS      = 5;
    localparam int BYTE_BITS     = 8;
    localparam int SYMS_PER_QUAD = 8;
    localparam int NUM_ALPHA     = 32;
    localparam int ALPHA_REGS    = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ALPHA_0  = 3'd0,
        CFG_ALPHA_8  = 3'd1,
        CFG_ALPHA_16 = 3'd2,
        CFG_ALPHA_24 = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol_char;
        logic       end_of_message;
    } t_out_item;

    // Work plan for one byte: up to three alphabet symbols, then padding
    typedef struct packed {
        logic [SYM_BITS-1:0] idx0;
        logic [SYM_BITS-1:0] idx1;
        logic [SYM_BITS-1:0] idx2;
        logic [1:0]          nsym;
        logic [3:0]          ntot;
        logic                fin;
    } t_plan;

endpackage

// ----- rtl/core/b32enc_alpha.sv -----
module b32enc_alpha (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [b32enc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [b32enc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic [b32enc_pkg::SYM_BITS-1:0]     i_look_idx,
    output logic [7:0]                          o_look_char
);

    logic [b32enc_pkg::CFG_DATA_BITS-1:0] r_alpha [b32enc_pkg::ALPHA_REGS];

    // Capture alphabet words; drop writes beyond the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < b32enc_pkg::ALPHA_REGS; k++) begin
                r_alpha[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                b32enc_pkg::CFG_ALPHA_0:  r_alpha[0] <= i_cfg_data;
                b32enc_pkg::CFG_ALPHA_8:  r_alpha[1] <= i_cfg_data;
                b32enc_pkg::CFG_ALPHA_16: r_alpha[2] <= i_cfg_data;
                b32enc_pkg::CFG_ALPHA_24: r_alpha[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Select word by the upper index bits, byte by the lower ones
    assign o_look_char = r_alpha[i_look_idx[4:3]][{i_look_idx[2:0], 3'b000} +: 8];

endmodule

// ----- rtl/core/b32enc_pack.sv -----
module b32enc_pack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  b32enc_pkg::t_in_item  i_item,
    output b32enc_pkg::t_plan     o_plan
);

    logic [3:0]  r_left_bits;
    logic [2:0]  r_left_count;
    logic [2:0]  r_pos;
    logic [3:0]  n_left_bits;
    logic [2:0]  n_left_count;
    logic [2:0]  n_pos;

    logic [11:0] bit_buf;
    logic [3:0]  cnt_raw;
    logic [3:0]  cnt;
    logic        two;
    logic [3:0]  sh0;
    logic [3:0]  sh1;
    logic [3:0]  rem;
    logic [11:0] mask;
    logic [3:0]  left;
    logic [8:0]  flush_wide;
    logic        has_flush;
    logic [1:0]  nsym;
    logic [2:0]  pos_after;
    logic [2:0]  pads;
    logic [3:0]  tot;

    // Split the buffered bits into 5-bit groups, most significant first
    always_comb begin
        bit_buf    = {r_left_bits, i_item.data_byte};
        cnt_raw    = {1'b0, r_left_count} + 4'd8;
        cnt        = (cnt_raw > 4'd12) ? 4'd12 : cnt_raw;
        two        = (cnt >= 4'd10);
        sh0        = cnt - 4'd5;
        sh1        = cnt - 4'd10;
        rem        = two ? sh1 : sh0;
        mask       = (12'd1 << rem) - 12'd1;
        left       = 4'(bit_buf & mask);
        flush_wide = {5'd0, left} << (4'd5 - rem);
        has_flush  = i_item.final_byte && (rem != 4'd0);
        nsym       = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
        pos_after  = r_pos + {1'b0, nsym};
        pads       = i_item.final_byte ? (3'd0 - pos_after) : 3'd0;
        tot        = {2'b00, nsym} + {1'b0, pads};

        // With a single data group the flush symbol takes the second slot
        o_plan.idx0 = 5'(bit_buf >> sh0);
        o_plan.idx1 = two ? 5'(bit_buf >> sh1) : flush_wide[4:0];
        o_plan.idx2 = flush_wide[4:0];
        o_plan.nsym = nsym;
        o_plan.ntot = (tot > 4'(b32enc_pkg::SYMS_PER_QUAD)) ?
                      4'(b32enc_pkg::SYMS_PER_QUAD) : tot;
        o_plan.fin  = i_item.final_byte;
    end

    // Advance stream state on each transfer; clear it after the final byte
    always_comb begin
        n_left_bits  = r_left_bits;
        n_left_count = r_left_count;
        n_pos        = r_pos;
        if (i_load) begin
            if (i_item.final_byte) begin
                n_left_bits  = '0;
                n_left_count = '0;
                n_pos        = '0;
            end else begin
                n_left_bits  = left;
                n_left_count = rem[2:0];
                n_pos        = pos_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits  <= '0;
            r_left_count <= '0;
            r_pos        <= '0;
        end else begin
            r_left_bits  <= n_left_bits;
            r_left_count <= n_left_count;
            r_pos        <= n_pos;
        end
    end

endmodule

// ----- rtl/core/b32enc_seq.sv -----
module b32enc_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    output logic                            o_load,
    input  b32enc_pkg::t_plan               i_plan,
    output logic [b32enc_pkg::SYM_BITS-1:0] o_look_idx,
    input  logic [7:0]                      i_look_char,
    output logic                            o_out_valid,
    output b32enc_pkg::t_out_item           o_out_data,
    input  logic                            i_out_stall
);

    logic                  r_busy;
    logic                  n_busy;
    b32enc_pkg::t_plan     r_plan;
    b32enc_pkg::t_plan     n_plan;
    logic [2:0]            r_step;
    logic [2:0]            n_step;
    logic                  r_out_valid;
    logic                  n_out_valid;
    b32enc_pkg::t_out_item r_out_data;
    b32enc_pkg::t_out_item n_out_data;

    logic out_free;
    logic emit;
    logic last;
    logic is_pad;

    // Handshake: take a new byte once the held one sends its last symbol
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        emit       = r_busy && out_free;
        last       = ({1'b0, r_step} == (r_plan.ntot - 4'd1));
        is_pad     = (r_step >= {1'b0, r_plan.nsym});
        o_in_stall = r_busy && !(emit && last);
        o_load     = i_in_valid && !o_in_stall;
    end

    // Pick the alphabet index for the current step
    always_comb begin
        case (r_step[1:0])
            2'd0:    o_look_idx = r_plan.idx0;
            2'd1:    o_look_idx = r_plan.idx1;
            default: o_look_idx = r_plan.idx2;
        endcase
    end

    // Hold the plan, advance the step, fill the result register
    always_comb begin
        n_busy      = r_busy;
        n_plan      = r_plan;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (emit) begin
            n_step                    = r_step + 3'd1;
            n_out_valid               = 1'b1;
            n_out_data.symbol_char    = is_pad ? b32enc_pkg::PAD_CHAR : i_look_char;
            n_out_data.end_of_message = r_plan.fin && last;
            if (last) begin
                n_busy = 1'b0;
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_load) begin
            n_busy = 1'b1;
            n_plan = i_plan;
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan     <= n_plan;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/base32_encoder.sv -----
// Channel   Direction  Handshake                    Payload
// in        sink       i_in_valid / o_in_stall      i_in_data  (t_in_item)
// out       source     o_out_valid / i_out_stall    o_out_data (t_out_item)
// cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One symbol leaves per cycle from a registered output while the output is not
// stalled. A byte makes one or two symbols, and up to eight for the final byte
// with its flush symbol and padding. The next byte is taken in the cycle
// its predecessor sends its last symbol. Reset is synchronous and clears the
// alphabet to zero and the stream state. A stall on the output holds the
// result register and, through it, the input.
module base32_encoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  b32enc_pkg::t_in_item                 i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output b32enc_pkg::t_out_item                o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [b32enc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [b32enc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    logic                            load;
    b32enc_pkg::t_plan               plan;
    logic [b32enc_pkg::SYM_BITS-1:0] look_idx;
    logic [7:0]                      look_char;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    b32enc_alpha u_alpha (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_look_idx  (look_idx),
        .o_look_char (look_char)
    );

    b32enc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (i_in_data),
        .o_plan  (plan)
    );

    b32enc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_load      (load),
        .i_plan      (plan),
        .o_look_idx  (look_idx),
        .i_look_char (look_char),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // A transferred byte shows a valid result once the plan register and then the result register have taken it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ##2 o_out_valid)
        else $error("accepted byte produced no result");

    // Every byte yields at least one symbol and padding never undercuts data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (plan.nsym != 2'd0) && (plan.ntot >= {2'b00, plan.nsym}))
        else $error("inconsistent symbol plan");

    // No flush or padding in the middle of a message
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !i_in_data.final_byte) |-> (plan.ntot == {2'b00, plan.nsym}))
        else $error("padding planned for a non-final byte");

endmodule

// ----- test/base32_encoder_checker.sv -----
module base32_encoder_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  b32enc_pkg::t_in_item                 i_in_data,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  b32enc_pkg::t_out_item                i_out_data,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [b32enc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [b32enc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    // Shadow copy of the alphabet and the stream state
    logic [b32enc_pkg::CFG_DATA_BITS-1:0] alpha_words [b32enc_pkg::ALPHA_REGS];
    logic [3:0]                           held_bits;
    logic [2:0]                           held_count;
    logic [2:0]                           sym_pos;

    b32enc_pkg::t_out_item expected_symbols [$];
    b32enc_pkg::t_out_item want;
    int                    fails;

    assign o_fail_count = fails;

    function automatic logic [7:0] alpha_char(input logic [b32enc_pkg::SYM_BITS-1:0] code);
        return alpha_words[code[4:3]][code[2:0]*8 +: 8];
    endfunction

    // Predict the symbols one accepted byte produces and queue them in order
    task automatic encode_byte(input b32enc_pkg::t_in_item item);
        logic [11:0]                     acc;
        logic [b32enc_pkg::SYM_BITS-1:0] code;
        logic [7:0]                      chars [b32enc_pkg::SYMS_PER_QUAD];
        int                              cnt;
        int                              n;
        acc = {held_bits, item.data_byte};
        cnt = held_count + b32enc_pkg::BYTE_BITS;
        n   = 0;
        // Emit every complete group, most significant first
        while (cnt >= b32enc_pkg::SYM_BITS) begin
            code     = acc[cnt-1 -: b32enc_pkg::SYM_BITS];
            chars[n] = alpha_char(code);
            sym_pos  = sym_pos + 3'd1;
            cnt      = cnt - b32enc_pkg::SYM_BITS;
            n++;
        end
        held_count = 3'(cnt);
        held_bits  = acc[3:0] & ((4'd1 << cnt) - 4'd1);
        if (item.final_byte) begin
            // Zero-fill the leftover bits into one more group
            if (cnt > 0) begin
                code     = {1'b0, held_bits} << (b32enc_pkg::SYM_BITS - cnt);
                chars[n] = alpha_char(code);
                sym_pos  = sym_pos + 3'd1;
                n++;
            end
            // Pad to a whole block of eight symbols
            while (sym_pos != 3'd0 && n < b32enc_pkg::SYMS_PER_QUAD) begin
                chars[n] = b32enc_pkg::PAD_CHAR;
                sym_pos  = sym_pos + 3'd1;
                n++;
            end
            held_bits  = '0;
            held_count = '0;
            sym_pos    = '0;
        end
        for (int k = 0; k < n; k++) begin
            expected_symbols.push_back({chars[k], item.final_byte && (k == n - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < b32enc_pkg::ALPHA_REGS; r++) begin
                alpha_words[r] = '0;
            end
            held_bits  = '0;
            held_count = '0;
            sym_pos    = '0;
            fails      = 0;
            expected_symbols.delete();
        end else begin
            // Compare each output transfer with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (expected_symbols.size() == 0) begin
                    $display("%0t: unexpected symbol: expected none, got %02h eom %b",
                             $time, i_out_data.symbol_char, i_out_data.end_of_message);
                    fails++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_out_data.symbol_char !== want.symbol_char) begin
                        $display("%0t: symbol_char: expected %02h, got %02h",
                                 $time, want.symbol_char, i_out_data.symbol_char);
                        fails++;
                    end
                    if (i_out_data.end_of_message !== want.end_of_message) begin
                        $display("%0t: end_of_message: expected %b, got %b",
                                 $time, want.end_of_message, i_out_data.end_of_message);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_in_data);
            end
            // Indexes past the alphabet registers are dropped
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < b32enc_pkg::ALPHA_REGS) begin
                alpha_words[i_cfg_index] = i_cfg_data;
            end
        end
        o_pending <= expected_symbols.size();
    end

endmodule

// ----- test/tb_base32_encoder.sv -----
module tb_base32_encoder;

    localparam logic [b32enc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_NONE =
        3'(b32enc_pkg::ALPHA_REGS);
    localparam logic [b32enc_pkg::CFG_IDX_BITS-1:0] CFG_IDX_TOP  = '1;
    localparam int RANDOM_BYTES  = 240;
    localparam int PHASES        = 4;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 16;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    b32enc_pkg::t_in_item                 in_data;
    logic                                 out_valid;
    logic                                 out_stall;
    b32enc_pkg::t_out_item                out_data;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [b32enc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [b32enc_pkg::CFG_DATA_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_len  = 0;
    int phase_bytes;
    int msg_len;

    logic [b32enc_pkg::CFG_DATA_BITS-1:0] alpha [b32enc_pkg::ALPHA_REGS];
    string                                std_chars;

    base32_encoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    base32_encoder_checker symbol_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial begin
        #2000000;
        $display("base32_encoder: mismatch");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial begin
        forever begin
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                out_stall <= ($urandom_range(99, 0) < stall_pct);
                @(posedge clk);
            end
        end
    end

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic cfg_write(input logic [b32enc_pkg::CFG_IDX_BITS-1:0]  index,
                             input logic [b32enc_pkg::CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Leaves cfg_valid high as well
    task automatic load_alphabet();
        cfg_write(b32enc_pkg::CFG_ALPHA_0, alpha[0]);
        cfg_write(b32enc_pkg::CFG_ALPHA_8, alpha[1]);
        cfg_write(b32enc_pkg::CFG_ALPHA_16, alpha[2]);
        cfg_write(b32enc_pkg::CFG_ALPHA_24, alpha[3]);
    endtask

    // Offer one byte after a random gap and hold it until the transfer
    task automatic push_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {value, last};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom_range(255, 0));
            end
        endcase
    endfunction

    // Stop offering and wait until every predicted symbol has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset alphabet is all zero: code zero everywhere, then padding
        push_byte(8'hA5, 1'b1);
        drain();

        // Standard alphabet; writes past the last register must be ignored
        std_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
        for (int k = 0; k < b32enc_pkg::NUM_ALPHA; k++) begin
            alpha[k / 8][(k % 8) * 8 +: 8] = std_chars[k];
        end
        load_alphabet();
        cfg_write(CFG_IDX_NONE, {$urandom, $urandom});
        cfg_write(CFG_IDX_TOP, {$urandom, $urandom});
        cfg_valid <= 1'b0;

        // Every residue of message length mod 5, so every amount of padding
        send_text("f");
        send_text("fo");
        send_text("foo");
        send_text("foob");
        send_text("fooba");
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 84;
                    stall_pct = 0;
                    for (int r = 0; r < b32enc_pkg::ALPHA_REGS; r++) begin
                        alpha[r] = {$urandom, $urandom};
                    end
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 84;
                    for (int r = 0; r < b32enc_pkg::ALPHA_REGS; r++) begin
                        alpha[r] = '1;
                    end
                end
                default: begin
                    idle_pct  = 9;
                    stall_pct = 9;
                    for (int r = 0; r < b32enc_pkg::ALPHA_REGS; r++) begin
                        alpha[r] = {$urandom, $urandom};
                    end
                end
            endcase
            load_alphabet();
            cfg_valid <= 1'b0;
            // Hold the output off while bytes keep coming, to back up the input
            if (phase == 0) begin
                hold_len = LONG_HOLD;
            end
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / PHASES) begin
                msg_len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 11)
                                                      : $urandom_range(10, 1);
                for (int i = 0; i < msg_len; i++) begin
                    push_byte(pick_byte(), i == msg_len - 1);
                end
                phase_bytes += msg_len;
                if ($urandom_range(15, 0) == 0) begin
                    drain();
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("base32_encoder: match");
        end else begin
            $display("base32_encoder: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/b32enc_pkg.sv
rtl/core/b32enc_alpha.sv
rtl/core/b32enc_pack.sv
rtl/core/b32enc_seq.sv
rtl/core/base32_encoder.sv
test/base32_encoder_checker.sv
test/tb_base32_encoder.sv
